>>> sv/diec_pkg.sv
// ----------------------------------------------------------------------------
// diec_pkg
// Shared types and constants for the digital input edge capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package diec_pkg;

	localparam int NUM_PINS_DEF   = 16;
	localparam int RING_DEPTH_DEF = 128;
	localparam int PINS_MAX       = 16;
	localparam int PIN_W          = 4;
	localparam int TIME_W         = 64;
	localparam int WIN_W          = 18;
	localparam int CFG_IDX_W      = 2;
	localparam logic [9:0] MS_TO_US = 10'd1000;

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_POLL   = 2'd1;
	localparam logic [1:0] MODE_ARM    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DB_LO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DB_HI  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_POLL1 = 4'b0100,
		ST_POLL2 = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		LC_NONE,
		LC_ARM,
		LC_EDGE,
		LC_PAIR,
		LC_RET,
		LC_RING,
		LC_SETTLE
	} lane_cmd_t;

	typedef struct packed {
		logic              pub;
		logic              zero_db;
		logic              settle;
		logic              pair_pend;
		logic              pair_lvl;
		logic [TIME_W-1:0] pair_t;
		logic              ret_pend;
		logic              ret_lvl;
		logic [TIME_W-1:0] ret_t;
		logic [TIME_W-1:0] first_t;
	} lane_st_t;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [PIN_W-1:0]  pin;
		logic              level;
	} ring_entry_t;

	function automatic logic [PIN_W-1:0] lowest_idx(input logic [PINS_MAX-1:0] v);
		logic [PIN_W-1:0] r;
		r = '0;
		for (int i = PINS_MAX - 1; i >= 0; i--) begin
			if (v[i]) r = PIN_W'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/diec_lane.sv
// ----------------------------------------------------------------------------
// diec_lane
// Per-pin state: published level, debounce episode, queued pair/return edges.
// ----------------------------------------------------------------------------
`default_nettype none

module diec_lane (
	input  logic                      clk,
	input  logic                      arst_n,
	input  diec_pkg::lane_cmd_t       cmd,
	input  logic                      lvl,
	input  logic [diec_pkg::TIME_W-1:0] t,
	input  logic [diec_pkg::TIME_W-1:0] now,
	input  logic                      en,
	input  logic [7:0]                db,
	output diec_pkg::lane_st_t        st
);
	import diec_pkg::*;

	logic              pub_q, uns_q, pairp_q, pairl_q, retp_q, retl_q;
	logic [TIME_W-1:0] first_q, last_q, pairt_q, rett_q;
	logic [WIN_W-1:0]  win_q;
	logic              settle_s1;
	logic [TIME_W-1:0] elapsed;
	logic              zero_db;

	assign zero_db = (db == 8'd0);
	assign elapsed = now - last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= '0;
			settle_s1 <= 1'b0;
		end else begin
			win_q     <= WIN_W'(db) * WIN_W'(MS_TO_US);
			settle_s1 <= !zero_db && en && uns_q && (elapsed >= TIME_W'(win_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_q   <= 1'b0;
			uns_q   <= 1'b0;
			pairp_q <= 1'b0;
			pairl_q <= 1'b0;
			retp_q  <= 1'b0;
			retl_q  <= 1'b0;
			first_q <= '0;
			last_q  <= '0;
			pairt_q <= '0;
			rett_q  <= '0;
		end else begin
			case (cmd)
				LC_ARM: begin
					pub_q <= lvl;
					uns_q <= 1'b0;
				end
				LC_EDGE: begin
					if (!uns_q) begin
						first_q <= t;
						uns_q   <= 1'b1;
					end
					last_q <= t;
				end
				LC_PAIR: begin
					pairp_q <= 1'b0;
					pub_q   <= pairl_q;
				end
				LC_RET: begin
					retp_q <= 1'b0;
					pub_q  <= retl_q;
				end
				LC_RING: begin
					if (lvl == pub_q) begin
						pairp_q <= 1'b1;
						pairl_q <= lvl;
						pairt_q <= t;
					end else begin
						pub_q <= lvl;
					end
				end
				LC_SETTLE: begin
					uns_q <= 1'b0;
					if (lvl != pub_q) begin
						pub_q <= lvl;
					end else begin
						retp_q <= 1'b1;
						retl_q <= pub_q;
						rett_q <= (last_q > first_q) ? last_q : first_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		st.pub       = pub_q;
		st.zero_db   = zero_db;
		st.settle    = settle_s1;
		st.pair_pend = pairp_q;
		st.pair_lvl  = pairl_q;
		st.pair_t    = pairt_q;
		st.ret_pend  = retp_q;
		st.ret_lvl   = retl_q;
		st.ret_t     = rett_q;
		st.first_t   = first_q;
	end

endmodule

`default_nettype wire

>>> sv/diec_ring.sv
// ----------------------------------------------------------------------------
// diec_ring
// Edge ring: one slot kept free, pushes into a full ring are counted as drops.
// ----------------------------------------------------------------------------
`default_nettype none

module diec_ring #(
	parameter int DEPTH = diec_pkg::RING_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  diec_pkg::ring_entry_t wr_entry,
	input  logic                  pop,
	output diec_pkg::ring_entry_t rd_entry,
	output logic                  empty,
	output logic [31:0]           drops
);
	import diec_pkg::*;

	localparam int AW = $clog2(DEPTH);

	ring_entry_t   mem [DEPTH];
	ring_entry_t   rd_q;
	logic [AW-1:0] head_q, tail_q, head_nx, tail_nx;
	logic [31:0]   drop_q;
	logic          full;

	assign head_nx = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign full    = (head_nx == tail_q);
	assign empty   = (head_q == tail_q);

	always_ff @(posedge clk) begin
		if (push && !full) mem[head_q] <= wr_entry;
		rd_q <= mem[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			drop_q <= '0;
		end else begin
			if (push) begin
				if (full) drop_q <= drop_q + 32'd1;
				else head_q <= head_nx;
			end
			if (pop) tail_q <= tail_nx;
		end
	end

	assign rd_entry = rd_q;
	assign drops    = drop_q;

	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n) !(push && pop))
		else $error("ring push and pop in the same cycle");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty ring");
	a_full_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |=> head_q == $past(head_q))
		else $error("head moved on a dropped push");

endmodule

`default_nettype wire

>>> sv/digital_input_edge_event_capture.sv
// Sample: accept, then a scan state that pushes changed zero-debounce pins into the
// ring, lowest pin first; poll: accept, POLL1, POLL2, then the result register, with
// POLL2 held while the result is stalled; arm: applied at accept. One item in work
// at a time. The ring push scan (one ring write port) sets the sample duration.
// Reset (arst_n low, asynchronous) clears pin state, ring pointers, drop count and
// configuration; ring storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// digital_input_edge_event_capture
// Pin lanes with debounce plus edge ring; polls merge lane and ring findings.
// ----------------------------------------------------------------------------
`default_nettype none

module digital_input_edge_event_capture #(
	parameter int NUM_PINS   = diec_pkg::NUM_PINS_DEF,
	parameter int RING_DEPTH = diec_pkg::RING_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [diec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     mode,
	input  logic [15:0]                    pin_levels,
	input  logic [63:0]                    time_us,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           event_valid,
	output logic [3:0]                     event_pin,
	output logic                           event_level,
	output logic [63:0]                    event_time_us,
	output logic [31:0]                    drop_count
);
	import diec_pkg::*;

	localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

	state_t              state_q;
	logic [15:0]         en_q;
	logic [63:0]         dblo_q, dbhi_q;
	logic [NUM_PINS-1:0] prev_q, chg_q, lvl_q;
	logic [TIME_W-1:0]   time_q;

	lane_st_t            st [NUM_PINS];
	lane_cmd_t           cmd [NUM_PINS];
	logic [NUM_PINS-1:0] lane_lvl;
	logic [TIME_W-1:0]   lane_t;
	logic [NUM_PINS-1:0] zero_v, pair_v, ret_v, settle_v, pub_v;

	logic                in_acc, out_free, fire;
	logic [NUM_PINS-1:0] push_v, push_oh, push_rest;
	logic [PIN_W-1:0]    push_idx;
	ring_entry_t         wr_entry, rd;
	logic                ring_empty, ring_push, ring_pop;
	logic [31:0]         drops;

	lane_cmd_t           tgt_cmd;
	logic [PW-1:0]       tgt_idx;
	logic                ev_v, ev_lvl;
	logic [PIN_W-1:0]    ev_pin, sel;
	logic [TIME_W-1:0]   ev_t;

	logic                out_valid_q, ev_valid_q, ev_level_q;
	logic [3:0]          ev_pin_q;
	logic [63:0]         ev_time_q;
	logic [31:0]         drop_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign fire     = (state_q == ST_POLL2) && out_free;

	for (genvar g = 0; g < NUM_PINS; g++) begin : g_lane
		logic [7:0] db;
		if (g < 8) begin : g_lo
			assign db = dblo_q[8*g +: 8];
		end else begin : g_hi
			assign db = dbhi_q[8*(g-8) +: 8];
		end
		diec_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[g]),
			.lvl    (lane_lvl[g]),
			.t      (lane_t),
			.now    (time_q),
			.en     (en_q[g]),
			.db     (db),
			.st     (st[g])
		);
		assign zero_v[g]   = st[g].zero_db;
		assign pair_v[g]   = st[g].pair_pend;
		assign ret_v[g]    = st[g].ret_pend;
		assign settle_v[g] = st[g].settle;
		assign pub_v[g]    = st[g].pub;
	end

	// ring push scan, lowest changed zero-debounce pin first
	assign push_v    = chg_q & zero_v;
	assign push_oh   = push_v & (~push_v + 1'b1);
	assign push_rest = push_v & ~push_oh;
	assign push_idx  = lowest_idx(PINS_MAX'(push_v));
	assign ring_push = (state_q == ST_SCAN) && (|push_v);
	assign ring_pop  = fire && (tgt_cmd == LC_RING);

	always_comb begin
		wr_entry.t     = time_q;
		wr_entry.pin   = push_idx;
		wr_entry.level = lvl_q[push_idx[PW-1:0]];
	end

	diec_ring #(.DEPTH(RING_DEPTH)) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (ring_push),
		.wr_entry (wr_entry),
		.pop      (ring_pop),
		.rd_entry (rd),
		.empty    (ring_empty),
		.drops    (drops)
	);

	// poll merge: pair, then return, then ring, then settled pin
	always_comb begin
		tgt_cmd = LC_NONE;
		tgt_idx = '0;
		ev_v    = 1'b0;
		ev_pin  = '0;
		ev_lvl  = 1'b0;
		ev_t    = '0;
		sel     = '0;
		if (|pair_v) begin
			sel     = lowest_idx(PINS_MAX'(pair_v));
			tgt_idx = sel[PW-1:0];
			tgt_cmd = LC_PAIR;
			ev_v    = 1'b1;
			ev_pin  = sel;
			ev_lvl  = st[tgt_idx].pair_lvl;
			ev_t    = st[tgt_idx].pair_t;
		end else if (|ret_v) begin
			sel     = lowest_idx(PINS_MAX'(ret_v));
			tgt_idx = sel[PW-1:0];
			tgt_cmd = LC_RET;
			ev_v    = 1'b1;
			ev_pin  = sel;
			ev_lvl  = st[tgt_idx].ret_lvl;
			ev_t    = st[tgt_idx].ret_t;
		end else if (!ring_empty) begin
			tgt_idx = rd.pin[PW-1:0];
			tgt_cmd = LC_RING;
			ev_v    = 1'b1;
			ev_pin  = PIN_W'(tgt_idx);
			ev_lvl  = rd.level ^ (rd.level == pub_v[tgt_idx]);
			ev_t    = rd.t;
		end else if (|settle_v) begin
			sel     = lowest_idx(PINS_MAX'(settle_v));
			tgt_idx = sel[PW-1:0];
			tgt_cmd = LC_SETTLE;
			ev_v    = 1'b1;
			ev_pin  = sel;
			ev_lvl  = lvl_q[tgt_idx] ^ (lvl_q[tgt_idx] == pub_v[tgt_idx]);
			ev_t    = st[tgt_idx].first_t;
		end
	end

	assign lane_t = (state_q == ST_POLL2) ? rd.t : time_q;

	always_comb begin
		for (int i = 0; i < NUM_PINS; i++) begin
			cmd[i] = LC_NONE;
			if (in_acc && mode == MODE_ARM) cmd[i] = LC_ARM;
			else if (state_q == ST_SCAN && chg_q[i] && !zero_v[i]) cmd[i] = LC_EDGE;
			else if (fire && tgt_idx == PW'(i)) cmd[i] = tgt_cmd;
			if (state_q == ST_IDLE) lane_lvl[i] = pin_levels[i];
			else if (state_q == ST_POLL2 && tgt_cmd == LC_RING) lane_lvl[i] = rd.level;
			else lane_lvl[i] = lvl_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= '0;
			dblo_q <= '0;
			dbhi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE: en_q   <= cfg_data[15:0];
				CFG_DB_LO:  dblo_q <= cfg_data;
				CFG_DB_HI:  dbhi_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_q  <= '0;
			chg_q   <= '0;
			lvl_q   <= '0;
			time_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (mode)
							MODE_SAMPLE: begin
								chg_q   <= (pin_levels[NUM_PINS-1:0] ^ prev_q) &
									en_q[NUM_PINS-1:0];
								prev_q  <= pin_levels[NUM_PINS-1:0];
								lvl_q   <= pin_levels[NUM_PINS-1:0];
								time_q  <= time_us;
								state_q <= ST_SCAN;
							end
							MODE_POLL: begin
								lvl_q   <= pin_levels[NUM_PINS-1:0];
								time_q  <= time_us;
								state_q <= ST_POLL1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					chg_q <= push_rest;
					if (push_rest == '0) state_q <= ST_IDLE;
				end
				ST_POLL1: state_q <= ST_POLL2;
				ST_POLL2: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_valid_q <= ev_v;
			ev_pin_q   <= ev_pin;
			ev_level_q <= ev_lvl;
			ev_time_q  <= ev_t;
			drop_q     <= drops;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_valid   = ev_valid_q;
	assign event_pin     = ev_pin_q;
	assign event_level   = ev_level_q;
	assign event_time_us = ev_time_q;
	assign drop_count    = drop_q;

	a_load_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_POLL2))
		else $error("result loaded outside poll merge");
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && push_rest == '0) |=> state_q == ST_IDLE)
		else $error("scan did not finish");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result beat dropped while stalled");

endmodule

`default_nettype wire
